@@ hdl/vasr_pkg.sv @@
// ----------------------------------------------------------------------------
// vasr_pkg
// Types and constants shared by the lane-sum / shift-relu datapath.
// ----------------------------------------------------------------------------
package vasr_pkg;

  localparam int WORD_HALF_W = 64;
  localparam int LANE_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int NUM_LANES   = 4;
  localparam int LANE_BYTES  = LANE_W / BYTE_W;
  localparam int ADDR_W      = 12;
  localparam int BANK_W      = 4;
  localparam int WCOUNT_W    = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = WCOUNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_BANK  = 2'd2;

  typedef enum logic {
    MODE_ACCUM = 1'b0,
    MODE_RELU  = 1'b1
  } mode_t;

  typedef struct packed {
    logic [WORD_HALF_W-1:0] word_low;
    logic [WORD_HALF_W-1:0] word_high;
  } in_item_t;

  typedef struct packed {
    logic [WORD_HALF_W-1:0] result_low;
    logic [WORD_HALF_W-1:0] result_high;
    logic [ADDR_W-1:0]      write_address;
    logic [BANK_W-1:0]      write_bank;
    logic                   job_done;
  } out_item_t;

  typedef struct packed {
    mode_t                  mode;
    logic                   last;
    logic [ADDR_W-1:0]      addr;
    logic [WORD_HALF_W-1:0] relu_low;
    logic [WORD_HALF_W-1:0] relu_high;
    logic [LANE_W-1:0]      pair_low;
    logic [LANE_W-1:0]      pair_high;
  } stage_t;

endpackage

@@ hdl/vasr_stream_if.sv @@
// ----------------------------------------------------------------------------
// vasr_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface vasr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hdl/vector_accumulate_shift_relu.sv @@
// ----------------------------------------------------------------------------
// vector_accumulate_shift_relu
// Lane-sum accumulate or shift-then-relu over a job of 128-bit words.
// ----------------------------------------------------------------------------
// usage:
//   word_in     valid/ready channel, one 128-bit word per transfer, as two halves
//   result_out  valid/ready channel of result words with address, bank, done
//   cfg_*       write port: mode, word_count, dest_bank; write only when idle
// mode accumulate: the four 32-bit lanes of every word go into a wrapping sum,
//   and the last word of the job gives one result holding that sum at address 0
// mode relu: every word gives one result at its index in the job, each signed
//   byte halved and clamped at zero; the last word carries job_done
// timing: four lanes work side by side, pair sums are registered, the merge
//   stage adds them into the sum and loads the output register; results pass
//   both registers; one word per cycle sustained while result_out.ready is high
// stall: the output register holds while result_out.ready is low, one more
//   word waits in the lane stage, then word_in.ready drops
// reset: clears word index, sum and valid flags; mode 0, word_count 1, bank 0
// ----------------------------------------------------------------------------
module vector_accumulate_shift_relu #(
  parameter int MAX_WORDS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [vasr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vasr_pkg::CFG_DATA_W-1:0] cfg_data,
  vasr_stream_if.sink                     word_in,
  vasr_stream_if.source                   result_out
);
  import vasr_pkg::*;

  localparam int IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CLOG_L = $clog2(MAX_WORDS + 1);
  localparam int LEN_W  = (CLOG_L > WCOUNT_W) ? CLOG_L : WCOUNT_W;

  mode_t               mode;
  logic [WCOUNT_W-1:0] word_count;
  logic [BANK_W-1:0]   dest_bank;

  logic [IDX_W-1:0]        word_index;
  logic [LEN_W-1:0]        count_ext;
  logic [LEN_W-1:0]        job_len;
  logic [LEN_W-1:0]        index_inc;
  logic                    last;
  logic [IDX_W+ADDR_W-1:0] addr_ext;
  logic                    accept;
  logic                    take;

  logic [LANE_W-1:0] lane_in   [NUM_LANES];
  logic [LANE_W-1:0] lane_relu [NUM_LANES];

  logic   stage_valid;
  stage_t stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_ACCUM;
      word_count <= WCOUNT_W'(1);
      dest_bank  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:       mode       <= mode_t'(cfg_data[0]);
        REG_WORD_COUNT: word_count <= cfg_data[WCOUNT_W-1:0];
        REG_DEST_BANK:  dest_bank  <= cfg_data[BANK_W-1:0];
        default: ;
      endcase
    end
  end

  // job length clamped to 1..MAX_WORDS
  always_comb begin
    count_ext = LEN_W'(word_count);
    if (count_ext == '0) begin
      job_len = LEN_W'(1);
    end else if (count_ext > LEN_W'(MAX_WORDS)) begin
      job_len = LEN_W'(MAX_WORDS);
    end else begin
      job_len = count_ext;
    end
  end

  assign index_inc = LEN_W'(word_index) + LEN_W'(1);
  assign last      = index_inc >= job_len;
  assign addr_ext  = {{ADDR_W{1'b0}}, word_index};
  assign accept    = word_in.valid && word_in.ready;
  assign word_in.ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
    end else if (accept) begin
      word_index <= last ? '0 : index_inc[IDX_W-1:0];
    end
  end

  assign lane_in[0] = word_in.data.word_low[LANE_W-1:0];
  assign lane_in[1] = word_in.data.word_low[WORD_HALF_W-1:LANE_W];
  assign lane_in[2] = word_in.data.word_high[LANE_W-1:0];
  assign lane_in[3] = word_in.data.word_high[WORD_HALF_W-1:LANE_W];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    vasr_lane u_lane (
      .lane (lane_in[g]),
      .relu (lane_relu[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (take) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.mode      <= mode;
      stage.last      <= last;
      stage.addr      <= addr_ext[ADDR_W-1:0];
      stage.relu_low  <= {lane_relu[1], lane_relu[0]};
      stage.relu_high <= {lane_relu[3], lane_relu[2]};
      stage.pair_low  <= lane_in[0] + lane_in[1];
      stage.pair_high <= lane_in[2] + lane_in[3];
    end
  end

  vasr_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage       (stage),
    .bank        (dest_bank),
    .take        (take),
    .result_out  (result_out)
  );

`ifndef SYNTHESIS
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !take |=> stage_valid && $stable(stage))
    else $error("lane stage lost a word while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> word_in.ready)
    else $error("input stalled with empty lane stage");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !stage_valid && !result_out.valid && (word_index == '0))
    else $error("pipeline not cleared by reset");
`endif

endmodule

@@ hdl/vasr_lane.sv @@
// ----------------------------------------------------------------------------
// vasr_lane
// One 32-bit lane: halve each signed byte and clamp non-positive results.
// ----------------------------------------------------------------------------
module vasr_lane (
  input  logic [vasr_pkg::LANE_W-1:0] lane,
  output logic [vasr_pkg::LANE_W-1:0] relu
);
  import vasr_pkg::*;

  always_comb begin
    relu = '0;
    for (int k = 0; k < LANE_BYTES; k++) begin
      // positive after the shift only for 2..127
      if (!lane[k*BYTE_W + BYTE_W-1] && (lane[k*BYTE_W + 1 +: BYTE_W-2] != '0)) begin
        relu[k*BYTE_W +: BYTE_W] = {1'b0, lane[k*BYTE_W + 1 +: BYTE_W-1]};
      end
    end
  end

endmodule

@@ hdl/vasr_merge.sv @@
// ----------------------------------------------------------------------------
// vasr_merge
// Combines the lane results: running lane sum or relu word, output register.
// ----------------------------------------------------------------------------
module vasr_merge (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        stage_valid,
  input  vasr_pkg::stage_t            stage,
  input  logic [vasr_pkg::BANK_W-1:0] bank,
  output logic                        take,
  vasr_stream_if.source               result_out
);
  import vasr_pkg::*;

  logic [LANE_W-1:0] running_sum;
  logic [LANE_W-1:0] sum_next;
  logic              emit;
  out_item_t         result;
  logic              result_valid;

  assign take     = stage_valid && (!result_valid || result_out.ready);
  assign sum_next = running_sum + stage.pair_low + stage.pair_high;
  assign emit     = (stage.mode == MODE_RELU) || stage.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        if (stage.last) begin
          running_sum <= '0;
        end else if (stage.mode == MODE_ACCUM) begin
          running_sum <= sum_next;
        end
      end
      if (take && emit) begin
        result_valid <= 1'b1;
      end else if (result_out.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      result.write_bank <= bank;
      result.job_done   <= stage.last;
      if (stage.mode == MODE_ACCUM) begin
        result.result_low    <= {{(WORD_HALF_W-LANE_W){1'b0}}, sum_next};
        result.result_high   <= '0;
        result.write_address <= '0;
      end else begin
        result.result_low    <= stage.relu_low;
        result.result_high   <= stage.relu_high;
        result.write_address <= stage.addr;
      end
    end
  end

  assign result_out.valid = result_valid;
  assign result_out.data  = result;

endmodule
